@@ hdl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assertion macros
// clocked property checks that drop out of the build when SYNTH is set
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// implication or plain property under reset
`define ASSERT_PROP(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// expression that must never be true out of reset
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define ASSERT_PROP(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg)
`endif

`endif

@@ hdl/id3fp_pkg.sv @@
// ----------------------------------------------------------------------------
// id3fp_pkg
// types, codes and helpers shared by the id3v2 frame stream parser
// ----------------------------------------------------------------------------
package id3fp_pkg;

    // walk phase, one-hot
    typedef enum logic [3:0] {
        PH_TAG  = 4'b0001,
        PH_FHDR = 4'b0010,
        PH_BODY = 4'b0100,
        PH_DONE = 4'b1000
    } phase_t;

    // byte label on the result channel
    typedef enum logic [1:0] {
        KIND_TAG_HDR   = 2'd0,
        KIND_FRAME_HDR = 2'd1,
        KIND_CONTENT   = 2'd2,
        KIND_PAD       = 2'd3
    } kind_t;

    // configuration register indexes
    typedef enum logic [0:0] {
        CFG_TARGET_ID = 1'b0,
        CFG_STOP      = 1'b1
    } cfg_index_t;

    localparam logic [3:0]  HC_SIZE_START  = 4'd6;   // tag size bytes 6..9
    localparam logic [3:0]  HC_LAST        = 4'd9;   // last of 10 header bytes
    localparam logic [3:0]  HC_FSIZE_FIRST = 4'd4;   // frame size bytes 4..7
    localparam logic [3:0]  HC_FSIZE_LAST  = 4'd7;
    localparam logic [28:0] OFFSET_MAX     = 29'h1FFF_FFFF;
    localparam logic [7:0]  PAD_BYTE       = 8'h00;

    typedef struct packed {
        logic [31:0] target_id;
        logic        stop_after_match;
    } cfg_t;

    typedef struct packed {
        logic [7:0]  out_byte;
        kind_t       byte_kind;
        logic        frame_match;
        logic [27:0] frame_length;
        logic [27:0] tag_length;
        logic        frame_end;
        logic        walk_end;
        logic        not_found;
    } result_t;

    typedef struct packed {
        logic done;
        logic in_body;
    } status_t;

    // append the 7 low bits of a synchsafe byte
    function automatic logic [27:0] sync_push(input logic [27:0] acc, input logic [7:0] b);
        sync_push = {acc[20:0], b[6:0]};
    endfunction

endpackage

@@ hdl/id3fp_walker.sv @@
// ----------------------------------------------------------------------------
// id3fp_walker
// parse state and per-byte labelling logic, one byte per transaction
// ----------------------------------------------------------------------------
module id3fp_walker (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_acc,
    input  logic [7:0]          in_byte,
    input  logic                first_byte,
    input  id3fp_pkg::cfg_t     cfg,
    output id3fp_pkg::result_t res,
    output id3fp_pkg::status_t status
);

    id3fp_pkg::phase_t phase_reg, phase_next, cur_phase;
    logic [3:0]  hc_reg, hc_next, cur_hc;
    logic [28:0] offset_reg, offset_next, cur_offset;
    logic [27:0] tag_size_reg, tag_size_next, cur_tag;
    logic [31:0] id_reg, id_next, cur_id;
    logic [27:0] size_reg, size_next, cur_size;
    logic [27:0] left_reg, left_next, cur_left;
    logic        seen_reg, seen_next, cur_seen;
    logic        hit_reg, hit_next, cur_hit;
    logic [27:0] left_dec;
    logic [27:0] size_upd;

    always_comb begin
        // restart mark clears the parse state before this byte is used
        cur_phase  = first_byte ? id3fp_pkg::PH_TAG : phase_reg;
        cur_hc     = first_byte ? 4'd0 : hc_reg;
        cur_offset = first_byte ? 29'd0 : offset_reg;
        cur_tag    = first_byte ? 28'd0 : tag_size_reg;
        cur_id     = first_byte ? 32'd0 : id_reg;
        cur_size   = first_byte ? 28'd0 : size_reg;
        cur_left   = first_byte ? 28'd0 : left_reg;
        cur_seen   = first_byte ? 1'b0 : seen_reg;
        cur_hit    = first_byte ? 1'b0 : hit_reg;

        phase_next    = cur_phase;
        hc_next       = cur_hc;
        offset_next   = cur_offset;
        tag_size_next = cur_tag;
        id_next       = cur_id;
        size_next     = cur_size;
        left_next     = cur_left;
        seen_next     = cur_seen;
        hit_next      = cur_hit;
        size_upd      = id3fp_pkg::sync_push(cur_size, in_byte);
        left_dec      = (cur_left != 28'd0) ? cur_left - 28'd1 : 28'd0;

        res.out_byte     = in_byte;
        res.byte_kind    = id3fp_pkg::KIND_PAD;
        res.frame_match  = 1'b0;
        res.frame_length = 28'd0;
        res.frame_end    = 1'b0;
        res.walk_end     = 1'b0;
        res.not_found    = 1'b0;

        if (cur_phase != id3fp_pkg::PH_DONE && cur_offset != id3fp_pkg::OFFSET_MAX) begin
            offset_next = cur_offset + 29'd1;
        end

        unique case (cur_phase)
            id3fp_pkg::PH_TAG: begin
                res.byte_kind = id3fp_pkg::KIND_TAG_HDR;
                if (cur_hc >= id3fp_pkg::HC_SIZE_START) begin
                    size_next = size_upd;
                end
                if (cur_hc >= id3fp_pkg::HC_LAST) begin
                    tag_size_next = size_next;
                    size_next     = 28'd0;
                    hc_next       = 4'd0;
                    phase_next    = id3fp_pkg::PH_FHDR;
                end else begin
                    hc_next = cur_hc + 4'd1;
                end
            end
            id3fp_pkg::PH_FHDR: begin
                if (cur_hc == 4'd0 && ((cur_offset > {1'b0, cur_tag}) ||
                                       (in_byte == id3fp_pkg::PAD_BYTE))) begin
                    // padding or tag end on the first id byte
                    res.walk_end  = 1'b1;
                    res.not_found = !cur_seen;
                    phase_next    = id3fp_pkg::PH_DONE;
                end else begin
                    res.byte_kind = id3fp_pkg::KIND_FRAME_HDR;
                    if (cur_hc < id3fp_pkg::HC_FSIZE_FIRST) begin
                        id_next = {cur_id[23:0], in_byte};
                    end else if (cur_hc == id3fp_pkg::HC_FSIZE_FIRST) begin
                        size_next = {21'd0, in_byte[6:0]};
                    end else if (cur_hc <= id3fp_pkg::HC_FSIZE_LAST) begin
                        size_next = size_upd;
                    end
                    if (cur_hc >= id3fp_pkg::HC_LAST) begin
                        hit_next         = (cur_id == cfg.target_id);
                        seen_next        = cur_seen | hit_next;
                        res.frame_match  = hit_next;
                        res.frame_length = cur_size;
                        left_next        = cur_size;
                        hc_next          = 4'd0;
                        if (cur_size == 28'd0) begin
                            res.frame_end = 1'b1;
                            if (hit_next && cfg.stop_after_match) begin
                                res.walk_end = 1'b1;
                                phase_next   = id3fp_pkg::PH_DONE;
                            end else begin
                                phase_next = id3fp_pkg::PH_FHDR;
                            end
                        end else begin
                            phase_next = id3fp_pkg::PH_BODY;
                        end
                    end else begin
                        hc_next = cur_hc + 4'd1;
                    end
                end
            end
            id3fp_pkg::PH_BODY: begin
                res.byte_kind    = id3fp_pkg::KIND_CONTENT;
                res.frame_match  = cur_hit;
                res.frame_length = cur_size;
                left_next        = left_dec;
                if (left_dec == 28'd0) begin
                    res.frame_end = 1'b1;
                    hc_next       = 4'd0;
                    if (cur_hit && cfg.stop_after_match) begin
                        res.walk_end = 1'b1;
                        phase_next   = id3fp_pkg::PH_DONE;
                    end else begin
                        phase_next = id3fp_pkg::PH_FHDR;
                    end
                end
            end
            default: begin
                res.byte_kind = id3fp_pkg::KIND_PAD;
            end
        endcase

        res.tag_length = tag_size_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= id3fp_pkg::PH_TAG;
            hc_reg       <= 4'd0;
            offset_reg   <= 29'd0;
            tag_size_reg <= 28'd0;
            id_reg       <= 32'd0;
            size_reg     <= 28'd0;
            left_reg     <= 28'd0;
            seen_reg     <= 1'b0;
            hit_reg      <= 1'b0;
        end else if (in_acc) begin
            phase_reg    <= phase_next;
            hc_reg       <= hc_next;
            offset_reg   <= offset_next;
            tag_size_reg <= tag_size_next;
            id_reg       <= id_next;
            size_reg     <= size_next;
            left_reg     <= left_next;
            seen_reg     <= seen_next;
            hit_reg      <= hit_next;
        end
    end

    assign status.done    = (phase_reg == id3fp_pkg::PH_DONE);
    assign status.in_body = (phase_reg == id3fp_pkg::PH_BODY);

endmodule

@@ hdl/id3fp_out_stage.sv @@
// ----------------------------------------------------------------------------
// id3fp_out_stage
// result register with backpressure toward the input side
// ----------------------------------------------------------------------------
module id3fp_out_stage (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                load,
    input  id3fp_pkg::result_t  res_in,
    output logic                can_load,
    output logic                out_valid,
    input  logic                out_ready,
    output id3fp_pkg::result_t  res_out
);

    logic               valid_reg, valid_next;
    id3fp_pkg::result_t res_reg;

    // a held result leaves in the same cycle a new one is loaded
    assign can_load   = !valid_reg || out_ready;
    assign valid_next = load || (valid_reg && !out_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            res_reg <= res_in;
        end
    end

    assign out_valid = valid_reg;
    assign res_out   = res_reg;

endmodule

@@ hdl/id3v2_frame_stream_parser.sv @@
// ----------------------------------------------------------------------------
// id3v2_frame_stream_parser
// labels the bytes of an id3v2 tag and flags the frame whose id is sought
//
//   channel | dir | handshake          | payload
//   s_      | in  | s_tvalid/s_tready  | tdata: in_byte; tuser: first_byte
//   m_      | out | m_tvalid/m_tready  | tdata: byte, frame/tag length;
//           |     |                    | tuser: kind, flags; tlast: frame end
//   cfg_    | in  | cfg_valid/cfg_ready| index 0 target id, 1 stop after match
//
// one byte per clock while s_tready is high; each result appears in the cycle after its byte is taken
// parse state and result register sit on either side of one level of logic
// reset (aresetn low, synchronous) clears the walk and both config registers
// s_tready drops only while a result is held and m_tready is low
// cfg_ready is always high
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module id3v2_frame_stream_parser (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] in_byte
    input  logic [0:0]  s_tuser,    // [0] first_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,    // [7:0] out_byte, [35:8] frame_length, [63:36] tag_length
    output logic [4:0]  m_tuser,    // [1:0] byte_kind, [2] frame_match, [3] walk_end,
                                    // [4] not_found
    output logic        m_tlast,    // frame_end
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [0:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    id3fp_pkg::cfg_t    cfg_reg;
    id3fp_pkg::result_t walk_res;
    id3fp_pkg::result_t out_res;
    id3fp_pkg::status_t st;
    logic               in_acc;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.target_id        <= 32'd0;
            cfg_reg.stop_after_match <= 1'b0;
        end else if (cfg_valid && cfg_ready) begin
            unique case (id3fp_pkg::cfg_index_t'(cfg_index))
                id3fp_pkg::CFG_TARGET_ID: cfg_reg.target_id        <= cfg_data;
                id3fp_pkg::CFG_STOP:      cfg_reg.stop_after_match <= cfg_data[0];
                default:                  cfg_reg                  <= cfg_reg;
            endcase
        end
    end

    assign in_acc = s_tvalid && s_tready;

    id3fp_walker u_walker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_acc     (in_acc),
        .in_byte    (s_tdata),
        .first_byte (s_tuser[0]),
        .cfg        (cfg_reg),
        .res        (walk_res),
        .status     (st)
    );

    id3fp_out_stage u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .load      (in_acc),
        .res_in    (walk_res),
        .can_load  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .res_out   (out_res)
    );

    assign m_tdata = {out_res.tag_length, out_res.frame_length, out_res.out_byte};
    assign m_tuser = {out_res.not_found, out_res.walk_end, out_res.frame_match,
                      out_res.byte_kind};
    assign m_tlast = out_res.frame_end;

    // a finished walk leaves the parser parked until a restart mark
    `ASSERT_PROP(a_walk_end_parks, aclk, aresetn, (in_acc && walk_res.walk_end) |=> st.done, "walk end did not park the parser")
    // parked parser labels every unmarked byte as padding
    `ASSERT_PROP(a_done_is_pad, aclk, aresetn, (in_acc && st.done && !s_tuser[0]) |-> (walk_res.byte_kind == id3fp_pkg::KIND_PAD && !walk_res.walk_end), "byte after walk end not padding")
    // inside a frame body an unmarked byte is content
    `ASSERT_PROP(a_body_is_content, aclk, aresetn, (in_acc && st.in_body && !s_tuser[0]) |-> (walk_res.byte_kind == id3fp_pkg::KIND_CONTENT), "body byte not labelled content")
    // every taken byte shows up on the result side next cycle
    `ASSERT_PROP(a_result_follows, aclk, aresetn, in_acc |=> m_tvalid, "accepted byte produced no result")
    // not found is only raised on the walk end byte
    `ASSERT_NEVER(a_nf_needs_end, aclk, aresetn, in_acc && walk_res.not_found && !walk_res.walk_end, "not found without walk end")

endmodule
